// ===== rtl/core/pppl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppl_pkg: shared definitions for the pinned page pool
// Defaults, response status codes and the structs that pass between the
// controller and the slot cells.
// ----------------------------------------------------------------------------
package pppl_pkg;

   localparam int SLOTS_DEF    = 8;
   localparam int AGE_BITS_DEF = 16;
   localparam int PIN_BITS_DEF = 8;

   localparam int PAGE_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 3;
   localparam int PIN_OUT_W  = 8;

   // request function codes
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] RSP_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_LOADED = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_PUT    = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_ABSENT = 3'd4;

   // flags carried by the scan token along the cell chain
   typedef struct packed {
      logic tok;    // token present at this stage
      logic hit;    // a resident slot holds the requested page
      logic found;  // an eviction candidate with nonzero age was seen
      logic free;   // an empty slot was seen
   } scan_flags_type;

   // per-cell update command, valid in the commit cycle
   typedef struct packed {
      logic apply;     // commit cycle
      logic touch;     // age all resident slots but the touched one
      logic age_zero;  // this cell is the touched slot
      logic pin_inc;   // this cell is hit by a get
      logic pin_dec;   // this cell is hit by a put
      logic evict;     // this cell is the evicted victim
      logic load;      // this cell takes the new page
   } cell_cmd_type;

endpackage : pppl_pkg
`default_nettype wire

// ===== rtl/core/pppl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppl_cell: one slot of the page pool
// Holds valid, page id, pin count and age; merges its slot into the scan
// token and hands the token to the next cell; applies the commit command.
// ----------------------------------------------------------------------------
module pppl_cell #(
   parameter int IDX_BITS = 3,
   parameter int AGE_BITS = pppl_pkg::AGE_BITS_DEF,
   parameter int PIN_BITS = pppl_pkg::PIN_BITS_DEF,
   parameter logic [IDX_BITS-1:0] CELL_INDEX = '0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pppl_pkg::PAGE_W-1:0]    req_page,
   input  pppl_pkg::cell_cmd_type         cmd,
   input  pppl_pkg::scan_flags_type       scan_in_flags,
   input  logic [IDX_BITS-1:0]            scan_in_hit_idx,
   input  logic [PIN_BITS-1:0]            scan_in_hit_pins,
   input  logic [AGE_BITS-1:0]            scan_in_best_age,
   input  logic [IDX_BITS-1:0]            scan_in_best_idx,
   input  logic [PIN_BITS-1:0]            scan_in_best_pins,
   input  logic [pppl_pkg::PAGE_W-1:0]    scan_in_best_page,
   input  logic [IDX_BITS-1:0]            scan_in_free_idx,
   output pppl_pkg::scan_flags_type       scan_out_flags,
   output logic [IDX_BITS-1:0]            scan_out_hit_idx,
   output logic [PIN_BITS-1:0]            scan_out_hit_pins,
   output logic [AGE_BITS-1:0]            scan_out_best_age,
   output logic [IDX_BITS-1:0]            scan_out_best_idx,
   output logic [PIN_BITS-1:0]            scan_out_best_pins,
   output logic [pppl_pkg::PAGE_W-1:0]    scan_out_best_page,
   output logic [IDX_BITS-1:0]            scan_out_free_idx
);

   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
   localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

   // slot state
   logic                        valid_ff, valid_in;
   logic [pppl_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [PIN_BITS-1:0]         pins_ff, pins_in;
   logic [AGE_BITS-1:0]         age_ff, age_in;

   // scan stage register
   pppl_pkg::scan_flags_type    flags_ff, flags_in;
   logic [IDX_BITS-1:0]         hit_idx_ff, hit_idx_in;
   logic [PIN_BITS-1:0]         hit_pins_ff, hit_pins_in;
   logic [AGE_BITS-1:0]         best_age_ff, best_age_in;
   logic [IDX_BITS-1:0]         best_idx_ff, best_idx_in;
   logic [PIN_BITS-1:0]         best_pins_ff, best_pins_in;
   logic [pppl_pkg::PAGE_W-1:0] best_page_ff, best_page_in;
   logic [IDX_BITS-1:0]         free_idx_ff, free_idx_in;

   // merge this slot into the token; strict compare keeps ties at the lower slot
   always_comb begin
      flags_in     = scan_in_flags;
      hit_idx_in   = scan_in_hit_idx;
      hit_pins_in  = scan_in_hit_pins;
      best_age_in  = scan_in_best_age;
      best_idx_in  = scan_in_best_idx;
      best_pins_in = scan_in_best_pins;
      best_page_in = scan_in_best_page;
      free_idx_in  = scan_in_free_idx;
      if (valid_ff && !scan_in_flags.hit && (page_ff == req_page)) begin
         flags_in.hit = 1'b1;
         hit_idx_in   = CELL_INDEX;
         hit_pins_in  = pins_ff;
      end
      if (valid_ff && (age_ff > scan_in_best_age)) begin
         flags_in.found = 1'b1;
         best_age_in    = age_ff;
         best_idx_in    = CELL_INDEX;
         best_pins_in   = pins_ff;
         best_page_in   = page_ff;
      end
      if (!valid_ff && !scan_in_flags.free) begin
         flags_in.free = 1'b1;
         free_idx_in   = CELL_INDEX;
      end
   end

   // commit update
   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      pins_in  = pins_ff;
      age_in   = age_ff;
      if (cmd.apply) begin
         if (cmd.load) begin
            valid_in = 1'b1;
            page_in  = req_page;
            pins_in  = PIN_ONE;
            age_in   = '0;
         end else begin
            if (cmd.evict) begin
               valid_in = 1'b0;
            end
            if (cmd.touch && valid_ff) begin
               if (cmd.age_zero) begin
                  age_in = '0;
               end else if (age_ff != AGE_MAX) begin
                  age_in = age_ff + AGE_BITS'(1);
               end
            end
            if (cmd.pin_inc && (pins_ff != PIN_MAX)) begin
               pins_in = pins_ff + PIN_ONE;
            end
            if (cmd.pin_dec && (pins_ff != '0)) begin
               pins_in = pins_ff - PIN_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      pins_ff      <= pins_in;
      age_ff       <= age_in;
      hit_idx_ff   <= hit_idx_in;
      hit_pins_ff  <= hit_pins_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      best_pins_ff <= best_pins_in;
      best_page_ff <= best_page_in;
      free_idx_ff  <= free_idx_in;
   end

   assign scan_out_flags     = flags_ff;
   assign scan_out_hit_idx   = hit_idx_ff;
   assign scan_out_hit_pins  = hit_pins_ff;
   assign scan_out_best_age  = best_age_ff;
   assign scan_out_best_idx  = best_idx_ff;
   assign scan_out_best_pins = best_pins_ff;
   assign scan_out_best_page = best_page_ff;
   assign scan_out_free_idx  = free_idx_ff;

endmodule : pppl_cell
`default_nettype wire

// ===== rtl/core/pinned_page_pool_lru_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_page_pool_lru_core: fully associative page pool with pins and ages
// A get pins and touches a page, loading it on a miss and evicting the
// oldest page if it is unpinned; a put unpins a resident page.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_func / req_page_id with start high; the
//   transaction is taken at an edge where busy is low. busy stays high
//   until the transaction has been committed.
//   Response channel: rsp_strobe is high for exactly one cycle with
//   rsp_status, rsp_slot, rsp_pin_count, rsp_evicted and rsp_evicted_page.
//   The receiver has no stall signal and must take the response then.
//   Timing: a scan token walks the chain of SLOTS cells, one cell per cycle,
//   collecting the hit slot, the oldest resident slot and the lowest empty
//   slot; a commit step then applies the update to all cells at once.
//   Busy is high while a transaction is in flight, and rsp_strobe is
//   high in the cycle in which busy drops again, so a new transaction can
//   be started in that same cycle.
//   Reset clears all slot valid bits, the token and the response strobe;
//   page ids, pins and ages of empty slots are never looked at.
// ----------------------------------------------------------------------------
module pinned_page_pool_lru_core #(
   parameter int SLOTS    = pppl_pkg::SLOTS_DEF,
   parameter int AGE_BITS = pppl_pkg::AGE_BITS_DEF,
   parameter int PIN_BITS = pppl_pkg::PIN_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [pppl_pkg::PAGE_W-1:0]      req_page_id,
   output logic                             rsp_strobe,
   output logic [pppl_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pppl_pkg::SLOT_OUT_W-1:0]  rsp_slot,
   output logic [pppl_pkg::PIN_OUT_W-1:0]   rsp_pin_count,
   output logic                             rsp_evicted,
   output logic [pppl_pkg::PAGE_W-1:0]      rsp_evicted_page
);

   localparam int IW     = $clog2(SLOTS);
   localparam int SLOT_W = pppl_pkg::SLOT_OUT_W;
   localparam int PCNT_W = pppl_pkg::PIN_OUT_W;
   localparam int PAGE_W = pppl_pkg::PAGE_W;
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
   localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

   // controller states
   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic              launch_ff;
   logic              req_func_ff;
   logic [PAGE_W-1:0] req_page_ff;
   logic              accept;
   logic              commit;

   // scan chain taps: stage 0 is the token source, stage SLOTS the last cell
   pppl_pkg::scan_flags_type sc_flags     [SLOTS+1];
   logic [IW-1:0]            sc_hit_idx   [SLOTS+1];
   logic [PIN_BITS-1:0]      sc_hit_pins  [SLOTS+1];
   logic [AGE_BITS-1:0]      sc_best_age  [SLOTS+1];
   logic [IW-1:0]            sc_best_idx  [SLOTS+1];
   logic [PIN_BITS-1:0]      sc_best_pins [SLOTS+1];
   logic [PAGE_W-1:0]        sc_best_page [SLOTS+1];
   logic [IW-1:0]            sc_free_idx  [SLOTS+1];

   // commit decision
   logic [pppl_pkg::STATUS_W-1:0] d_status;
   logic [IW-1:0]                 d_slot;
   logic [PIN_BITS-1:0]           d_pins;
   logic                          d_evicted;
   logic [PAGE_W-1:0]             d_evp;
   logic                          touch_en;
   logic [IW-1:0]                 touch_idx;
   logic                          pin_inc;
   logic                          pin_dec;
   logic                          evict_en;
   logic                          load_en;
   logic [IW-1:0]                 load_idx;

   // response registers
   logic                          rsp_strobe_ff;
   logic [pppl_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]             rsp_slot_ff;
   logic [PCNT_W-1:0]             rsp_pins_ff;
   logic                          rsp_evicted_ff;
   logic [PAGE_W-1:0]             rsp_evp_ff;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign commit = (state_ff == S_SCAN) && sc_flags[SLOTS].tok;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         launch_ff     <= accept;
         rsp_strobe_ff <= commit;
      end
   end

   // request is held for the whole scan; cells compare against it
   always_ff @(posedge clock) begin
      if (accept) begin
         req_func_ff <= req_func;
         req_page_ff <= req_page_id;
      end
   end

   // token source: empty token, launched in the cycle after acceptance
   assign sc_flags[0]     = '{tok: launch_ff, hit: 1'b0, found: 1'b0, free: 1'b0};
   assign sc_hit_idx[0]   = '0;
   assign sc_hit_pins[0]  = '0;
   assign sc_best_age[0]  = '0;
   assign sc_best_idx[0]  = '0;
   assign sc_best_pins[0] = '0;
   assign sc_best_page[0] = '0;
   assign sc_free_idx[0]  = '0;

   // Decision from the token at the end of the chain. A miss loads into the
   // lowest empty slot, or into the victim when that one sits lower.
   always_comb begin
      d_status  = pppl_pkg::RSP_ABSENT;
      d_slot    = '0;
      d_pins    = '0;
      d_evicted = 1'b0;
      d_evp     = '0;
      touch_en  = 1'b0;
      touch_idx = sc_hit_idx[SLOTS];
      pin_inc   = 1'b0;
      pin_dec   = 1'b0;
      evict_en  = 1'b0;
      load_en   = 1'b0;
      load_idx  = sc_free_idx[SLOTS];
      if (req_func_ff == pppl_pkg::FUNC_PUT) begin
         if (sc_flags[SLOTS].hit) begin
            pin_dec  = 1'b1;
            d_status = pppl_pkg::RSP_PUT;
            d_slot   = sc_hit_idx[SLOTS];
            d_pins   = (sc_hit_pins[SLOTS] == '0) ? '0 : sc_hit_pins[SLOTS] - PIN_ONE;
         end
      end else if (sc_flags[SLOTS].hit) begin
         pin_inc  = 1'b1;
         touch_en = 1'b1;
         d_status = pppl_pkg::RSP_HIT;
         d_slot   = sc_hit_idx[SLOTS];
         d_pins   = (sc_hit_pins[SLOTS] == PIN_MAX) ? PIN_MAX
                                                    : sc_hit_pins[SLOTS] + PIN_ONE;
      end else begin
         // oldest slot goes only when nobody holds a pin on it
         evict_en = sc_flags[SLOTS].found && (sc_best_pins[SLOTS] == '0);
         if (evict_en && (!sc_flags[SLOTS].free ||
                          (sc_best_idx[SLOTS] < sc_free_idx[SLOTS]))) begin
            load_idx = sc_best_idx[SLOTS];
         end
         if (sc_flags[SLOTS].free || evict_en) begin
            load_en   = 1'b1;
            touch_en  = 1'b1;
            touch_idx = load_idx;
            d_status  = pppl_pkg::RSP_LOADED;
            d_slot    = load_idx;
            d_pins    = PIN_ONE;
            d_evicted = evict_en;
            d_evp     = evict_en ? sc_best_page[SLOTS] : '0;
         end else begin
            d_status = pppl_pkg::RSP_FULL;
         end
      end
   end

   // chain of slot cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      localparam logic [IW-1:0] CELL_I = IW'(g);
      pppl_pkg::cell_cmd_type cmd;

      assign cmd.apply    = commit;
      assign cmd.touch    = touch_en;
      assign cmd.age_zero = (touch_idx == CELL_I);
      assign cmd.pin_inc  = pin_inc && (sc_hit_idx[SLOTS] == CELL_I);
      assign cmd.pin_dec  = pin_dec && (sc_hit_idx[SLOTS] == CELL_I);
      assign cmd.evict    = evict_en && (sc_best_idx[SLOTS] == CELL_I);
      assign cmd.load     = load_en && (load_idx == CELL_I);

      pppl_cell #(
         .IDX_BITS   (IW),
         .AGE_BITS   (AGE_BITS),
         .PIN_BITS   (PIN_BITS),
         .CELL_INDEX (CELL_I)
      ) u_cell (
         .clock              (clock),
         .reset              (reset),
         .req_page           (req_page_ff),
         .cmd                (cmd),
         .scan_in_flags      (sc_flags[g]),
         .scan_in_hit_idx    (sc_hit_idx[g]),
         .scan_in_hit_pins   (sc_hit_pins[g]),
         .scan_in_best_age   (sc_best_age[g]),
         .scan_in_best_idx   (sc_best_idx[g]),
         .scan_in_best_pins  (sc_best_pins[g]),
         .scan_in_best_page  (sc_best_page[g]),
         .scan_in_free_idx   (sc_free_idx[g]),
         .scan_out_flags     (sc_flags[g+1]),
         .scan_out_hit_idx   (sc_hit_idx[g+1]),
         .scan_out_hit_pins  (sc_hit_pins[g+1]),
         .scan_out_best_age  (sc_best_age[g+1]),
         .scan_out_best_idx  (sc_best_idx[g+1]),
         .scan_out_best_pins (sc_best_pins[g+1]),
         .scan_out_best_page (sc_best_page[g+1]),
         .scan_out_free_idx  (sc_free_idx[g+1])
      );
   end

   // response capture; slot and pin count report their low bits only
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff  <= d_status;
         rsp_slot_ff    <= SLOT_W'(d_slot);
         rsp_pins_ff    <= PCNT_W'(d_pins);
         rsp_evicted_ff <= d_evicted;
         rsp_evp_ff     <= d_evp;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_pin_count    = rsp_pins_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evp_ff;

endmodule : pinned_page_pool_lru_core
`default_nettype wire

// ===== rtl/core/pppl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppl_checker: port-level checks for the page pool core
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module pppl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_strobe,
   input wire logic [pppl_pkg::STATUS_W-1:0] rsp_status,
   input wire logic                          rsp_evicted
);

   // an accepted transaction makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after accepting a transaction");

   // every commit, and only a commit, ends the busy period with a response
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without a response");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("response outside the end of a transaction");

   // one response per transaction
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // an eviction only happens on a load
   a_evict_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> (rsp_status == pppl_pkg::RSP_LOADED))
      else $error("eviction reported without a load");

endmodule : pppl_checker

bind pinned_page_pool_lru_core pppl_checker u_pppl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_status  (rsp_status),
   .rsp_evicted (rsp_evicted)
);
`default_nettype wire
